// ===== rtl/core/gebp_pkg.sv =====
// Shared constants and the command type of the Golomb encoder and byte packer.
package gebp_pkg;

	// Width of the value field and of the divisor register.
	localparam int IN_W = 16;
	localparam int M_W = 16;
	localparam int BYTE_W = 8;

	// Only the low VALUE_WIDTH bits of a value are coded.
	localparam int VALUE_WIDTH = 16;
	localparam int DIV_W = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;

	// Largest quotient that is still coded.
	localparam int MAX_QUOTIENT = 255;
	localparam int QUOT_W = $clog2(MAX_QUOTIENT + 1);

	// Tail of a code word: the terminating zero followed by up to M_W remainder bits.
	localparam int TAIL_W = M_W + 1;
	localparam int TLEN_W = $clog2(TAIL_W + 1);

	// Shared width of the down counters for the run of ones and the tail.
	localparam int LEFT_W = (QUOT_W > TLEN_W) ? QUOT_W : TLEN_W;
	localparam int SUM_W = LEFT_W + 2;
	localparam int FULL_W = SUM_W - 3;

	// Divisor after reset.
	localparam logic [M_W-1:0] DIVISOR_RESET = 16'd4;

	// Command queue between front and back; the depth is a power of two.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// One classified item, ready for the packer.
	typedef struct packed {
		logic              ovf;
		logic              eos;
		logic [QUOT_W-1:0] ones;
		logic [TAIL_W-1:0] tail;
		logic [TLEN_W-1:0] tail_len;
	} cmd_t;

endpackage

// ===== rtl/core/gebp_if.sv =====
// Handshake interfaces for the item, result and configuration channels.
interface gebp_item_if;
	logic                      valid;
	logic                      ready;
	logic [gebp_pkg::IN_W-1:0] value;
	logic                      end_of_stream;

	modport source (output valid, output value, output end_of_stream, input ready);
	modport sink (input valid, input value, input end_of_stream, output ready);
endinterface

interface gebp_result_if;
	logic                        valid;
	logic                        ready;
	logic [gebp_pkg::BYTE_W-1:0] out_byte;
	logic                        last_of_run;
	logic                        quotient_overflow;

	modport source (output valid, output out_byte, output last_of_run,
		output quotient_overflow, input ready);
	modport sink (input valid, input out_byte, input last_of_run,
		input quotient_overflow, output ready);
endinterface

interface gebp_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [gebp_pkg::M_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/gebp_front.sv =====
// Front end: divisor register, serial divider and code word classification.
module gebp_front (
	input  logic              clk,
	input  logic              arst_n,
	gebp_item_if.sink         item,
	gebp_cfg_if.sink          cfg,
	output gebp_pkg::cmd_t    cmd,
	output logic              cmd_valid,
	input  logic              cmd_ready
);

	localparam int STEP_W = $clog2(gebp_pkg::DIV_W);

	localparam logic [1:0] FS_IDLE = 2'd0;
	localparam logic [1:0] FS_DIV  = 2'd1;
	localparam logic [1:0] FS_PUSH = 2'd2;

	logic [1:0]                     state_q;
	logic [gebp_pkg::M_W-1:0]       divisor_q;
	logic [gebp_pkg::M_W-1:0]       m_q;
	logic [gebp_pkg::TLEN_W-1:0]    b_q;
	logic [gebp_pkg::M_W-1:0]       u_q;
	logic [gebp_pkg::DIV_W-1:0]     quo_q;
	logic [gebp_pkg::M_W-1:0]       rem_q;
	logic                           eos_q;
	logic [STEP_W-1:0]              step_q;

	logic [gebp_pkg::M_W-1:0]       m_eff;
	logic [gebp_pkg::M_W-1:0]       m_less;
	logic [gebp_pkg::TLEN_W-1:0]    b_eff;
	logic [gebp_pkg::M_W:0]         u_wide;
	logic [gebp_pkg::M_W:0]         shifted;
	logic [gebp_pkg::M_W:0]         diff;
	logic                           ge;
	logic                           lt;
	logic [gebp_pkg::M_W-1:0]       code;
	logic [gebp_pkg::TLEN_W-1:0]    len;

	// Register always writable; the user must do writes only while idle, unchecked.
	assign cfg.ready = 1'b1;
	assign item.ready = (state_q == FS_IDLE);

	// A zero divisor behaves as one. The remainder width is the bit length of M - 1.
	always_comb begin
		m_eff = (divisor_q == '0) ? gebp_pkg::M_W'(1) : divisor_q;
		m_less = m_eff - gebp_pkg::M_W'(1);
		b_eff = '0;
		for (int i = 0; i < gebp_pkg::M_W; i++) begin
			if (m_less[i]) begin
				b_eff = gebp_pkg::TLEN_W'(i + 1);
			end
		end
		u_wide = ({{gebp_pkg::M_W{1'b0}}, 1'b1} << b_eff) - {1'b0, m_eff};
	end

	// One restoring division step per cycle.
	always_comb begin
		shifted = {rem_q, quo_q[gebp_pkg::DIV_W-1]};
		ge = (shifted >= {1'b0, m_q});
		diff = shifted - {1'b0, m_q};
	end

	// Truncated binary coding of the remainder and the command word.
	always_comb begin
		lt = (rem_q < u_q);
		code = lt ? rem_q : (rem_q + u_q);
		len = lt ? (b_q - gebp_pkg::TLEN_W'(1)) : b_q;
		cmd.ovf = (32'(quo_q) > 32'(gebp_pkg::MAX_QUOTIENT));
		cmd.eos = eos_q;
		cmd.ones = gebp_pkg::QUOT_W'(quo_q);
		cmd.tail = {1'b0, code} << (gebp_pkg::TLEN_W'(gebp_pkg::M_W) - len);
		cmd.tail_len = len + gebp_pkg::TLEN_W'(1);
		cmd_valid = (state_q == FS_PUSH);
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q <= gebp_pkg::DIVISOR_RESET;
		end else if (cfg.valid) begin
			divisor_q <= cfg.data;
		end
	end

	// Sequencer: accept, divide, hand over.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
			step_q <= '0;
		end else begin
			unique case (state_q)
				FS_IDLE: begin
					if (item.valid) begin
						state_q <= FS_DIV;
						step_q <= STEP_W'(gebp_pkg::DIV_W - 1);
					end
				end
				FS_DIV: begin
					if (step_q == '0) begin
						state_q <= FS_PUSH;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				FS_PUSH: begin
					if (cmd_ready) begin
						state_q <= FS_IDLE;
					end
				end
				default: begin
					state_q <= FS_IDLE;
				end
			endcase
		end
	end

	// Divider datapath and per-item operands.
	always_ff @(posedge clk) begin
		if (state_q == FS_IDLE && item.valid) begin
			quo_q <= item.value[gebp_pkg::DIV_W-1:0];
			rem_q <= '0;
			m_q <= m_eff;
			b_q <= b_eff;
			u_q <= u_wide[gebp_pkg::M_W-1:0];
			eos_q <= item.end_of_stream;
		end else if (state_q == FS_DIV) begin
			rem_q <= ge ? diff[gebp_pkg::M_W-1:0] : shifted[gebp_pkg::M_W-1:0];
			quo_q <= {quo_q[gebp_pkg::DIV_W-2:0], ge};
		end
	end

endmodule

// ===== rtl/core/gebp_queue.sv =====
// Short command queue that decouples the front end from the packer.
module gebp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  gebp_pkg::cmd_t wr_cmd,
	input  logic           wr_valid,
	output logic           wr_ready,
	output gebp_pkg::cmd_t rd_cmd,
	output logic           rd_valid,
	input  logic           rd_ready
);

	gebp_pkg::cmd_t                entry_q [gebp_pkg::QUEUE_DEPTH];
	logic [gebp_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [gebp_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [gebp_pkg::QCNT_W-1:0]   count_q;
	logic                          push;
	logic                          pop;

	// Occupancy flags and the head entry.
	always_comb begin
		wr_ready = (count_q != gebp_pkg::QCNT_W'(gebp_pkg::QUEUE_DEPTH));
		rd_valid = (count_q != '0);
		push = wr_valid && wr_ready;
		pop = rd_valid && rd_ready;
		rd_cmd = entry_q[rd_ptr_q];
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gebp_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gebp_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + gebp_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - gebp_pkg::QCNT_W'(1);
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

// ===== rtl/core/gebp_back.sv =====
// Back end: packs runs of ones and code word tails MSB-first into bytes.
module gebp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  gebp_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	gebp_result_if.source  result
);

	localparam logic [2:0] BS_IDLE  = 3'd0;
	localparam logic [2:0] BS_ONES  = 3'd1;
	localparam logic [2:0] BS_TAIL  = 3'd2;
	localparam logic [2:0] BS_FLUSH = 3'd3;
	localparam logic [2:0] BS_OVF   = 3'd4;

	logic [2:0]                     state_q;
	logic [gebp_pkg::BYTE_W-1:0]    acc_q;
	logic [2:0]                     cnt_q;
	logic [gebp_pkg::QUOT_W-1:0]    ones_q;
	logic [gebp_pkg::TAIL_W-1:0]    tail_q;
	logic [gebp_pkg::TLEN_W-1:0]    tlen_q;
	logic [gebp_pkg::FULL_W-1:0]    full_left_q;
	logic                           flush_q;
	logic                           eos_q;
	logic                           out_valid_q;
	logic [gebp_pkg::BYTE_W-1:0]    out_byte_q;
	logic                           out_last_q;
	logic                           out_ovf_q;

	logic                           out_free;
	logic [3:0]                     avail;
	logic [gebp_pkg::LEFT_W-1:0]    cur_left;
	logic [3:0]                     k;
	logic [gebp_pkg::BYTE_W-1:0]    src;
	logic [2*gebp_pkg::BYTE_W-1:0]  wide;
	logic [gebp_pkg::BYTE_W-1:0]    new_acc;
	logic [gebp_pkg::BYTE_W-1:0]    pad_byte;
	logic                           fills;
	logic                           seg_done;
	logic                           packing;
	logic                           step_go;
	logic [gebp_pkg::SUM_W-1:0]     sum;
	logic                           emit;
	logic [gebp_pkg::BYTE_W-1:0]    emit_byte;
	logic                           emit_last;
	logic                           emit_ovf;

	assign cmd_ready = (state_q == BS_IDLE);
	assign result.valid = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.last_of_run = out_last_q;
	assign result.quotient_overflow = out_ovf_q;

	// Chunk of up to one byte's worth of bits taken from the current segment.
	always_comb begin
		out_free = !out_valid_q || result.ready;
		avail = 4'd8 - {1'b0, cnt_q};
		packing = (state_q == BS_ONES) || (state_q == BS_TAIL);
		cur_left = (state_q == BS_ONES) ? gebp_pkg::LEFT_W'(ones_q)
			: gebp_pkg::LEFT_W'(tlen_q);
		k = (cur_left >= gebp_pkg::LEFT_W'(avail)) ? avail : cur_left[3:0];
		src = (state_q == BS_ONES) ? '1 : tail_q[gebp_pkg::TAIL_W-1 -: gebp_pkg::BYTE_W];
		wide = {acc_q, src} << k;
		new_acc = wide[2*gebp_pkg::BYTE_W-1 -: gebp_pkg::BYTE_W];
		fills = (k == avail);
		seg_done = (cur_left == gebp_pkg::LEFT_W'(k));
		step_go = packing && (!fills || out_free);
		pad_byte = acc_q << avail;
		sum = gebp_pkg::SUM_W'(cnt_q) + gebp_pkg::SUM_W'(cmd.ones)
			+ gebp_pkg::SUM_W'(cmd.tail_len);
	end

	// Byte to hand to the output register in this cycle, if any.
	always_comb begin
		emit = 1'b0;
		emit_byte = new_acc;
		emit_last = 1'b0;
		emit_ovf = 1'b0;
		unique case (state_q)
			BS_ONES, BS_TAIL: begin
				emit = step_go && fills;
				emit_last = (full_left_q == gebp_pkg::FULL_W'(1)) && !flush_q;
			end
			BS_FLUSH: begin
				emit = out_free;
				emit_byte = pad_byte;
				emit_last = 1'b1;
			end
			BS_OVF: begin
				emit = out_free;
				emit_byte = (eos_q && cnt_q != '0) ? pad_byte : '0;
				emit_last = 1'b1;
				emit_ovf = 1'b1;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// Packer sequencer and bit accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
			acc_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				BS_IDLE: begin
					if (cmd_valid) begin
						if (cmd.ovf) begin
							state_q <= BS_OVF;
						end else if (cmd.ones != '0) begin
							state_q <= BS_ONES;
						end else begin
							state_q <= BS_TAIL;
						end
					end
				end
				BS_ONES, BS_TAIL: begin
					if (step_go) begin
						acc_q <= fills ? '0 : new_acc;
						cnt_q <= fills ? '0 : 3'(cnt_q + k[2:0]);
						if (seg_done) begin
							if (state_q == BS_ONES) begin
								state_q <= BS_TAIL;
							end else begin
								state_q <= flush_q ? BS_FLUSH : BS_IDLE;
							end
						end
					end
				end
				BS_FLUSH: begin
					if (out_free) begin
						acc_q <= '0;
						cnt_q <= '0;
						state_q <= BS_IDLE;
					end
				end
				BS_OVF: begin
					if (out_free) begin
						if (eos_q) begin
							acc_q <= '0;
							cnt_q <= '0;
						end
						state_q <= BS_IDLE;
					end
				end
				default: begin
					state_q <= BS_IDLE;
				end
			endcase
		end
	end

	// Segment counters and the byte count of the current item.
	always_ff @(posedge clk) begin
		if (state_q == BS_IDLE && cmd_valid) begin
			ones_q <= cmd.ones;
			tail_q <= cmd.tail;
			tlen_q <= cmd.tail_len;
			eos_q <= cmd.eos;
			full_left_q <= sum[gebp_pkg::SUM_W-1:3];
			flush_q <= cmd.eos && (sum[2:0] != 3'd0);
		end else if (step_go) begin
			if (state_q == BS_ONES) begin
				ones_q <= ones_q - gebp_pkg::QUOT_W'(k);
			end else begin
				tail_q <= tail_q << k;
				tlen_q <= tlen_q - gebp_pkg::TLEN_W'(k);
			end
			if (fills) begin
				full_left_q <= full_left_q - gebp_pkg::FULL_W'(1);
			end
		end
	end

	// Output register: a finished byte waits here while packing goes on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
			out_ovf_q <= emit_ovf;
		end
	end

endmodule

// ===== rtl/core/golomb_encoder_byte_packer.sv =====
// Top level of the Golomb encoder with MSB-first byte packer.
//
//  Channel  Direction  Payload                                        Handshake
//  item     in         value[15:0], end_of_stream                     valid/ready
//  result   out        out_byte[7:0], last_of_run, quotient_overflow  valid/ready
//  cfg      in         data[15:0] (divisor)                           valid/ready
//
// The front end takes one item at a time: it accepts it, runs the
// one-bit-per-cycle division by the divisor, then hands the command over.
// The packer takes a command, then packs the run of ones and the tail byte by
// byte, or reports an overflow instead; a partial byte is flushed at end of stream.
// Reset sets the divisor to 4 and clears the bit accumulator and all handshakes.
// A two-entry command queue and a byte register let front and packer stall apart.
module golomb_encoder_byte_packer (
	input  logic          clk,
	input  logic          arst_n,
	gebp_item_if.sink     item,
	gebp_result_if.source result,
	gebp_cfg_if.sink      cfg
);

	gebp_pkg::cmd_t front_cmd;
	logic           front_valid;
	logic           front_ready;
	gebp_pkg::cmd_t back_cmd;
	logic           back_valid;
	logic           back_ready;

	// Divider and classifier.
	gebp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg       (cfg),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// Command queue.
	gebp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_cmd   (front_cmd),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_cmd   (back_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	// Byte packer.
	gebp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.result    (result)
	);

endmodule

// ===== tb/sv/golomb_encoder_byte_packer_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Golomb encoder and byte packer, with its own code predictor.
module golomb_encoder_byte_packer_tb;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned MAX_WAIT = 13;
	localparam int unsigned HOLD_OFF_CYCLES = 600;
	localparam int unsigned MAX_REPORTS = 40;

	// One packed output byte together with its flags.
	typedef struct packed {
		logic [gebp_pkg::BYTE_W-1:0] out_byte;
		logic                        last_of_run;
		logic                        quotient_overflow;
	} code_byte_t;

	logic clk;
	logic arst_n;

	gebp_item_if   item_ch();
	gebp_result_if result_ch();
	gebp_cfg_if    cfg_ch();

	golomb_encoder_byte_packer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// Predicted bytes still to come, oldest first.
	code_byte_t expected_code_bytes[$];

	// Private copy of the packer state and of the divisor register.
	logic [gebp_pkg::BYTE_W-1:0] pend_bits;
	int unsigned                 pend_cnt;
	logic [gebp_pkg::M_W-1:0]    model_divisor;

	int unsigned mismatch_count;
	int unsigned cycle_count;
	bit          tx_idle;
	bit          rx_idle;
	int unsigned hold_req;

	// Free-running clock with a period of 2 ns.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: give up once the run has gone on far too long.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Some tests failed");
			$finish;
		end
	end

	// Appends one predicted byte at the tail of the queue.
	function automatic void queue_code_byte(input code_byte_t entry);
		expected_code_bytes = {expected_code_bytes, entry};
	endfunction

	// Appends one code bit and queues a byte once eight have gathered.
	function automatic void push_code_bit(input logic bit_v);
		pend_bits = {pend_bits[gebp_pkg::BYTE_W-2:0], bit_v};
		pend_cnt++;
		if (pend_cnt == gebp_pkg::BYTE_W) begin
			queue_code_byte(code_byte_t'{pend_bits, 1'b0, 1'b0});
			pend_bits = '0;
			pend_cnt = 0;
		end
	endfunction

	// Left-aligns the pending bits, pads with zeros and clears the packer.
	function automatic logic [gebp_pkg::BYTE_W-1:0] flush_pending();
		logic [gebp_pkg::BYTE_W-1:0] padded;
		padded = pend_bits << (gebp_pkg::BYTE_W - pend_cnt);
		pend_bits = '0;
		pend_cnt = 0;
		return padded;
	endfunction

	// Works out every byte that one accepted value produces.
	function automatic void predict_golomb_code(input logic [gebp_pkg::IN_W-1:0] value,
			input bit eos);
		longint unsigned n;
		longint unsigned m;
		longint unsigned q;
		int unsigned     r;
		int unsigned     nb;
		int unsigned     u;
		int unsigned     tail;
		int              tail_len;
		int              i;
		int unsigned     first;
		logic [gebp_pkg::BYTE_W-1:0] padded;

		first = expected_code_bytes.size();
		n = longint'(value) & ((64'd1 << gebp_pkg::VALUE_WIDTH) - 1);
		m = (model_divisor == '0) ? 1 : longint'(model_divisor);
		q = n / m;
		r = int'(n % m);

		// Too many ones to code: a single overflow byte, flushing if asked.
		if (q > gebp_pkg::MAX_QUOTIENT) begin
			padded = '0;
			if (eos && pend_cnt > 0)
				padded = flush_pending();
			queue_code_byte(code_byte_t'{padded, 1'b1, 1'b1});
			return;
		end

		nb = 0;
		while ((64'd1 << nb) < m)
			nb++;
		u = int'((64'd1 << nb) - m);

		// Unary quotient, terminating zero, then the truncated binary remainder.
		for (i = 0; i < int'(q); i++)
			push_code_bit(1'b1);
		push_code_bit(1'b0);
		if (r < u) begin
			tail = r;
			tail_len = int'(nb) - 1;
		end else begin
			tail = r + u;
			tail_len = int'(nb);
		end
		for (i = tail_len - 1; i >= 0; i--)
			push_code_bit(tail[i]);

		if (eos && pend_cnt > 0) begin
			padded = flush_pending();
			queue_code_byte(code_byte_t'{padded, 1'b0, 1'b0});
		end

		if (expected_code_bytes.size() > first)
			expected_code_bytes[expected_code_bytes.size() - 1].last_of_run = 1'b1;
	endfunction

	// Compares each accepted result with the oldest prediction.
	always @(posedge clk) begin : check_results
		code_byte_t got;
		code_byte_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.out_byte, result_ch.last_of_run, result_ch.quotient_overflow};
			if (expected_code_bytes.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < MAX_REPORTS)
					$display("%0t: expected none, actual %02h last %0b ovf %0b",
						$time, got.out_byte, got.last_of_run, got.quotient_overflow);
			end else begin
				want = expected_code_bytes.pop_front();
				if (got.out_byte !== want.out_byte || got.last_of_run !== want.last_of_run ||
						got.quotient_overflow !== want.quotient_overflow) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < MAX_REPORTS)
						$display("%0t: expected %02h/%0b/%0b, actual %02h/%0b/%0b",
							$time, want.out_byte, want.last_of_run,
							want.quotient_overflow, got.out_byte,
							got.last_of_run, got.quotient_overflow);
				end
			end
		end
	end

	// Result receiver: random stalls per transaction, or one long hold-off on request.
	initial begin : result_receiver
		int unsigned gap;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req != 0) begin
				gap = hold_req;
				hold_req = 0;
			end else begin
				gap = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
			end
			repeat (gap) begin
				result_ch.ready <= 1'b0;
				@(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
		end
	end

	// Offers one value and predicts its bytes once the transaction completes.
	task automatic send_item(input int unsigned value, input bit eos);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.value <= gebp_pkg::IN_W'(value);
		item_ch.end_of_stream <= eos;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		predict_golomb_code(gebp_pkg::IN_W'(value), eos);
	endtask

	// Waits until every predicted byte has arrived and the pipeline has settled.
	task automatic wait_until_drained();
		item_ch.valid <= 1'b0;
		while (expected_code_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Writes the divisor while the block is idle.
	task automatic write_divisor(input int unsigned m);
		wait_until_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= gebp_pkg::M_W'(m);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_ch.valid <= 1'b0;
		model_divisor = gebp_pkg::M_W'(m);
	endtask

	// Random value, mostly with a quotient that can be coded.
	function automatic int unsigned pick_value(input int unsigned m);
		int unsigned sel;
		int unsigned top;
		sel = $urandom_range(0, 99);
		top = m * (gebp_pkg::MAX_QUOTIENT + 1) - 1;
		if (top > 65535)
			top = 65535;
		if (sel < 10 && top < 65535)
			return $urandom_range(top + 1, 65535);
		else if (sel < 15)
			return $urandom_range(0, 65535);
		return $urandom_range(0, top);
	endfunction

	// Reset divisor of four: quotient limits, overflow with and without a flush request.
	task automatic test_reset_divisor();
		send_item(0, 1'b0);
		send_item(3, 1'b0);
		send_item(4, 1'b0);
		send_item(7, 1'b0);
		send_item(1023, 1'b0);
		send_item(1024, 1'b0);
		send_item(65535, 1'b1);
		// Code ends on a byte boundary, so the flush adds nothing.
		send_item(20, 1'b1);
		// Overflow with a flush request but nothing pending.
		send_item(65535, 1'b1);
	endtask

	// Divisor five: short and long remainder forms of truncated binary.
	task automatic test_truncated_remainder();
		write_divisor(5);
		send_item(0, 1'b0);
		send_item(1, 1'b0);
		send_item(2, 1'b0);
		send_item(3, 1'b0);
		send_item(4, 1'b0);
		send_item(9, 1'b1);
	endtask

	// Largest divisor, a zero divisor and a power of two.
	task automatic test_divisor_extremes();
		write_divisor(65535);
		send_item(0, 1'b0);
		send_item(1, 1'b0);
		send_item(65534, 1'b0);
		send_item(65535, 1'b1);
		write_divisor(0);
		send_item(0, 1'b0);
		send_item(200, 1'b0);
		send_item(255, 1'b1);
		send_item(256, 1'b0);
		write_divisor(32768);
		send_item(32767, 1'b0);
		send_item(65535, 1'b1);
	endtask

	// Random streams over a range of divisors and idling mixes.
	task automatic test_random_stream();
		int unsigned divisors[13];
		int unsigned p;
		int unsigned k;
		divisors = '{1, 2, 3, 7, 12, 100, 255, 256, 1000, 4096, 65535, 0, 0};
		divisors[11] = $urandom_range(1, 65535);
		divisors[12] = $urandom_range(1, 300);
		for (p = 0; p < 13; p++) begin
			write_divisor(divisors[p]);
			tx_idle = (p % 4 == 1) || (p % 4 == 3);
			rx_idle = (p % 4 == 2) || (p % 4 == 3);
			for (k = 0; k < 13; k++)
				send_item(pick_value(divisors[p]), $urandom_range(0, 4) == 0);
		end
	endtask

	// Long hold-off on the result side while values keep coming.
	task automatic test_result_backpressure();
		int unsigned k;
		write_divisor(3);
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		hold_req = HOLD_OFF_CYCLES;
		for (k = 0; k < 30; k++)
			send_item($urandom_range(0, 200), $urandom_range(0, 5) == 0);
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	// Stimulus sequence and final verdict.
	initial begin
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.value = '0;
		item_ch.end_of_stream = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		pend_bits = '0;
		pend_cnt = 0;
		model_divisor = gebp_pkg::DIVISOR_RESET;
		mismatch_count = 0;
		cycle_count = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_divisor();
		test_truncated_remainder();
		test_divisor_extremes();
		test_random_stream();
		test_result_backpressure();
		wait_until_drained();

		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
